// ===== hdl/cis_pkg.sv =====
// ----------------------------------------------------------------------------
// cis_pkg
// shared types and constants for the cbor item skipper
// ----------------------------------------------------------------------------
package cis_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEAD    = 3'd1,
        PH_ARG     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DONE    = 3'd4,
        PH_FAIL    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        FK_ARRAY  = 3'd0,
        FK_MAP    = 3'd1,
        FK_IARRAY = 3'd2,
        FK_IMAP   = 3'd3,
        FK_IBYTES = 3'd4,
        FK_ITEXT  = 3'd5
    } frame_kind_t;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2,
        ST_IDLE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       begin_item;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] item_length;
        logic [4:0]  nesting_depth;
    } out_item_t;

    localparam logic [7:0] BREAK_BYTE   = 8'hff;
    localparam logic [2:0] MAJOR_UINT   = 3'd0;
    localparam logic [2:0] MAJOR_NINT   = 3'd1;
    localparam logic [2:0] MAJOR_BYTES  = 3'd2;
    localparam logic [2:0] MAJOR_TEXT   = 3'd3;
    localparam logic [2:0] MAJOR_ARRAY  = 3'd4;
    localparam logic [2:0] MAJOR_MAP    = 3'd5;
    localparam logic [2:0] MAJOR_TAG    = 3'd6;
    localparam logic [2:0] MAJOR_SIMPLE = 3'd7;
    localparam logic [4:0] AI_ONE_BYTE  = 5'd24;
    localparam logic [4:0] AI_RESERVED  = 5'd28;
    localparam logic [4:0] AI_INDEF     = 5'd31;
    localparam logic [4:0] AI_FALSE     = 5'd20;
    localparam logic [4:0] AI_TRUE      = 5'd21;
    localparam logic [4:0] AI_NULL      = 5'd22;
    localparam logic [4:0] AI_FLOAT64   = 5'd27;
    localparam logic [15:0] LEN_SAT     = 16'hffff;

endpackage

// ===== hdl/cis_frame_stack.sv =====
// ----------------------------------------------------------------------------
// cis_frame_stack
// container frame storage with top read and end-of-item pop cascade
// ----------------------------------------------------------------------------
module cis_frame_stack #(
    parameter int MAX_DEPTH   = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                                    clk,
    input  logic [$clog2(MAX_DEPTH+1)-1:0]          sp,
    input  logic [$clog2(MAX_DEPTH+1)-1:0]          end_base,
    input  logic                                    wr_en,
    input  logic [((MAX_DEPTH>1)?$clog2(MAX_DEPTH):1)-1:0] wr_addr,
    input  cis_pkg::frame_kind_t                    wr_kind,
    input  logic [LENGTH_BITS:0]                    wr_rem,
    output cis_pkg::frame_kind_t                    top_kind,
    output logic [LENGTH_BITS:0]                    top_rem,
    output logic                                    casc_found,
    output logic [((MAX_DEPTH>1)?$clog2(MAX_DEPTH):1)-1:0] casc_idx,
    output cis_pkg::frame_kind_t                    casc_kind,
    output logic [LENGTH_BITS:0]                    casc_rem
);

    localparam int SPW = $clog2(MAX_DEPTH+1);
    localparam int IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int RW  = LENGTH_BITS + 1;

    cis_pkg::frame_kind_t kind_mem [MAX_DEPTH];
    logic [RW-1:0]        rem_mem  [MAX_DEPTH];
    // frame would close on its next decrement
    logic [MAX_DEPTH-1:0] fin_reg;

    logic [SPW-1:0] top_pos;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kind_mem[wr_addr] <= wr_kind;
            rem_mem[wr_addr]  <= wr_rem;
            fin_reg[wr_addr]  <= ((wr_kind == cis_pkg::FK_ARRAY) ||
                                  (wr_kind == cis_pkg::FK_MAP)) &&
                                 (wr_rem == RW'(1));
        end
    end

    assign top_pos  = sp - SPW'(1);
    assign top_kind = kind_mem[top_pos[IW-1:0]];
    assign top_rem  = rem_mem[top_pos[IW-1:0]];

    // highest frame below end_base that survives the decrement
    always_comb
    begin
        casc_found = 1'b0;
        casc_idx   = '0;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            if ((SPW'(i) < end_base) && !fin_reg[i])
            begin
                casc_found = 1'b1;
                casc_idx   = IW'(i);
            end
        end
    end

    assign casc_kind = kind_mem[casc_idx];
    assign casc_rem  = rem_mem[casc_idx];

endmodule

// ===== hdl/cbor_item_skipper_top.sv =====
// ----------------------------------------------------------------------------
// cbor_item_skipper_top
// an accepted request has its result in the output register in the next cycle;
// one byte per cycle unless in_stall holds the input, set by the single decode
// pass and the frame stack read plus pop search in front of the state registers.
// reset: parser idle, stack empty, length zero, output register empty.
// ----------------------------------------------------------------------------
module cbor_item_skipper_top #(
    parameter int MAX_DEPTH   = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cis_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output cis_pkg::out_item_t  out_item
);

    localparam int SPW = $clog2(MAX_DEPTH+1);
    localparam int IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int RW  = LENGTH_BITS + 1;

    cis_pkg::phase_t    phase_reg, phase_next;
    logic [SPW-1:0]     sp_reg, sp_next;
    logic [2:0]         hm_reg, hm_next;
    logic [63:0]        av_reg, av_next;
    logic [3:0]         abl_reg, abl_next;
    logic [LENGTH_BITS-1:0] pbl_reg, pbl_next;
    logic [15:0]        len_reg, len_next;
    logic               out_valid_reg, out_valid_next;
    cis_pkg::out_item_t out_item_reg, out_item_next;

    logic               accept;
    cis_pkg::phase_t    eff_phase;
    logic [SPW-1:0]     eff_sp;
    logic [2:0]         eff_hm;
    logic [63:0]        eff_av;
    logic [3:0]         eff_abl;
    logic [LENGTH_BITS-1:0] eff_pbl;
    logic [15:0]        eff_len;

    logic [7:0]         b;
    logic [2:0]         major;
    logic [4:0]         ai;
    logic               have_top;
    cis_pkg::status_t   st;
    logic               end_req, arg_done, push_req;
    logic [SPW-1:0]     end_base;
    logic [63:0]        arg_v;
    logic [2:0]         arg_major;
    cis_pkg::frame_kind_t push_kind;
    logic [RW-1:0]      push_rem;
    logic [2:0]         want_major;
    logic [31:0]        sp_wide;

    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    cis_pkg::frame_kind_t wr_kind;
    logic [RW-1:0]      wr_rem;
    cis_pkg::frame_kind_t top_kind, casc_kind;
    logic [RW-1:0]      top_rem, casc_rem;
    logic               casc_found;
    logic [IW-1:0]      casc_idx;

    cis_frame_stack #(
        .MAX_DEPTH   (MAX_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_stack (
        .clk        (clk),
        .sp         (eff_sp),
        .end_base   (end_base),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_kind    (wr_kind),
        .wr_rem     (wr_rem),
        .top_kind   (top_kind),
        .top_rem    (top_rem),
        .casc_found (casc_found),
        .casc_idx   (casc_idx),
        .casc_kind  (casc_kind),
        .casc_rem   (casc_rem)
    );

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign b     = in_item.data_byte;
    assign major = b[7:5];
    assign ai    = b[4:0];

    always_comb
    begin
        if (in_item.begin_item)
        begin
            eff_phase = cis_pkg::PH_HEAD;
            eff_sp    = '0;
            eff_hm    = '0;
            eff_av    = '0;
            eff_abl   = '0;
            eff_pbl   = '0;
            eff_len   = '0;
        end
        else
        begin
            eff_phase = phase_reg;
            eff_sp    = sp_reg;
            eff_hm    = hm_reg;
            eff_av    = av_reg;
            eff_abl   = abl_reg;
            eff_pbl   = pbl_reg;
            eff_len   = len_reg;
        end
    end

    assign have_top   = (eff_sp != '0);
    assign want_major = (top_kind == cis_pkg::FK_IBYTES) ? cis_pkg::MAJOR_BYTES
                                                         : cis_pkg::MAJOR_TEXT;

    // byte decode and state update
    always_comb
    begin
        phase_next = eff_phase;
        sp_next    = eff_sp;
        hm_next    = eff_hm;
        av_next    = eff_av;
        abl_next   = eff_abl;
        pbl_next   = eff_pbl;
        len_next   = eff_len;
        st         = cis_pkg::ST_BUSY;
        end_req    = 1'b0;
        end_base   = eff_sp;
        arg_done   = 1'b0;
        arg_v      = '0;
        arg_major  = eff_hm;
        push_req   = 1'b0;
        push_kind  = cis_pkg::FK_ARRAY;
        push_rem   = '0;
        wr_en      = 1'b0;
        wr_addr    = eff_sp[IW-1:0];
        wr_kind    = cis_pkg::FK_ARRAY;
        wr_rem     = '0;

        case (eff_phase)
            cis_pkg::PH_HEAD,
            cis_pkg::PH_ARG,
            cis_pkg::PH_PAYLOAD:
            begin
                if (eff_len != cis_pkg::LEN_SAT)
                begin
                    len_next = eff_len + 16'd1;
                end
            end
            default:
            begin
                st = cis_pkg::ST_IDLE;
            end
        endcase

        case (eff_phase)
            cis_pkg::PH_HEAD:
            begin
                if (b == cis_pkg::BREAK_BYTE)
                begin
                    if (!have_top || top_kind == cis_pkg::FK_ARRAY ||
                        top_kind == cis_pkg::FK_MAP)
                    begin
                        st = cis_pkg::ST_ERROR;
                    end
                    else if (top_kind == cis_pkg::FK_IMAP && top_rem != '0)
                    begin
                        st = cis_pkg::ST_ERROR;
                    end
                    else
                    begin
                        end_req  = 1'b1;
                        end_base = eff_sp - SPW'(1);
                    end
                end
                else if (have_top && (top_kind == cis_pkg::FK_IBYTES ||
                         top_kind == cis_pkg::FK_ITEXT) &&
                         (major != want_major || ai == cis_pkg::AI_INDEF))
                begin
                    st = cis_pkg::ST_ERROR;
                end
                else if (major == cis_pkg::MAJOR_TAG)
                begin
                    st = cis_pkg::ST_ERROR;
                end
                else if (major == cis_pkg::MAJOR_SIMPLE)
                begin
                    if (ai == cis_pkg::AI_FALSE || ai == cis_pkg::AI_TRUE ||
                        ai == cis_pkg::AI_NULL)
                    begin
                        end_req = 1'b1;
                    end
                    else if (ai == cis_pkg::AI_FLOAT64)
                    begin
                        pbl_next   = LENGTH_BITS'(8);
                        phase_next = cis_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        st = cis_pkg::ST_ERROR;
                    end
                end
                else
                begin
                    hm_next = major;
                    if (ai == cis_pkg::AI_INDEF)
                    begin
                        if (major == cis_pkg::MAJOR_UINT || major == cis_pkg::MAJOR_NINT)
                        begin
                            st = cis_pkg::ST_ERROR;
                        end
                        else
                        begin
                            push_req = 1'b1;
                            push_rem = '0;
                            case (major)
                                cis_pkg::MAJOR_BYTES: push_kind = cis_pkg::FK_IBYTES;
                                cis_pkg::MAJOR_TEXT:  push_kind = cis_pkg::FK_ITEXT;
                                cis_pkg::MAJOR_ARRAY: push_kind = cis_pkg::FK_IARRAY;
                                default:              push_kind = cis_pkg::FK_IMAP;
                            endcase
                        end
                    end
                    else if (ai >= cis_pkg::AI_RESERVED)
                    begin
                        st = cis_pkg::ST_ERROR;
                    end
                    else if (ai < cis_pkg::AI_ONE_BYTE)
                    begin
                        arg_done  = 1'b1;
                        arg_v     = 64'(ai);
                        arg_major = major;
                        av_next   = 64'(ai);
                    end
                    else
                    begin
                        av_next    = '0;
                        abl_next   = 4'd1 << (ai[1:0]);
                        phase_next = cis_pkg::PH_ARG;
                    end
                end
            end
            cis_pkg::PH_ARG:
            begin
                av_next  = {eff_av[55:0], b};
                abl_next = eff_abl - 4'd1;
                if (abl_next == '0)
                begin
                    arg_done  = 1'b1;
                    arg_v     = av_next;
                    arg_major = eff_hm;
                end
            end
            cis_pkg::PH_PAYLOAD:
            begin
                pbl_next = eff_pbl - LENGTH_BITS'(1);
                if (pbl_next == '0)
                begin
                    end_req = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (arg_done)
        begin
            if (arg_major == cis_pkg::MAJOR_UINT || arg_major == cis_pkg::MAJOR_NINT)
            begin
                end_req = 1'b1;
            end
            else if ((arg_v >> LENGTH_BITS) != '0)
            begin
                st = cis_pkg::ST_ERROR;
            end
            else if (arg_v == '0)
            begin
                end_req = 1'b1;
            end
            else if (arg_major == cis_pkg::MAJOR_BYTES || arg_major == cis_pkg::MAJOR_TEXT)
            begin
                pbl_next   = arg_v[LENGTH_BITS-1:0];
                phase_next = cis_pkg::PH_PAYLOAD;
            end
            else
            begin
                push_req = 1'b1;
                if (arg_major == cis_pkg::MAJOR_ARRAY)
                begin
                    push_kind = cis_pkg::FK_ARRAY;
                    push_rem  = {1'b0, arg_v[LENGTH_BITS-1:0]};
                end
                else
                begin
                    push_kind = cis_pkg::FK_MAP;
                    push_rem  = {arg_v[LENGTH_BITS-1:0], 1'b0};
                end
            end
        end

        if (push_req)
        begin
            if (eff_sp >= SPW'(MAX_DEPTH))
            begin
                st = cis_pkg::ST_ERROR;
            end
            else
            begin
                wr_en      = 1'b1;
                wr_addr    = eff_sp[IW-1:0];
                wr_kind    = push_kind;
                wr_rem     = push_rem;
                sp_next    = eff_sp + SPW'(1);
                phase_next = cis_pkg::PH_HEAD;
            end
        end

        // item or chunk closed: pop finished definite frames, count the next one
        if (end_req)
        begin
            if (!casc_found)
            begin
                sp_next    = '0;
                phase_next = cis_pkg::PH_DONE;
                st         = cis_pkg::ST_DONE;
            end
            else
            begin
                sp_next    = SPW'(casc_idx) + SPW'(1);
                phase_next = cis_pkg::PH_HEAD;
                wr_addr    = casc_idx;
                wr_kind    = casc_kind;
                if (casc_kind == cis_pkg::FK_ARRAY || casc_kind == cis_pkg::FK_MAP)
                begin
                    wr_en  = 1'b1;
                    wr_rem = casc_rem - RW'(1);
                end
                else if (casc_kind == cis_pkg::FK_IMAP)
                begin
                    wr_en  = 1'b1;
                    wr_rem = casc_rem ^ RW'(1);
                end
            end
        end

        if (st == cis_pkg::ST_BUSY && in_item.last_byte)
        begin
            st = cis_pkg::ST_ERROR;
        end
        if (st == cis_pkg::ST_ERROR)
        begin
            phase_next = cis_pkg::PH_FAIL;
        end

        wr_en = wr_en && accept;
    end

    assign sp_wide = 32'(sp_next);

    always_comb
    begin
        out_item_next.status        = st;
        out_item_next.item_length   = len_next;
        out_item_next.nesting_depth = sp_wide[4:0];
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cis_pkg::PH_IDLE;
            sp_reg        <= '0;
            hm_reg        <= '0;
            av_reg        <= '0;
            abl_reg       <= '0;
            pbl_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                sp_reg    <= sp_next;
                hm_reg    <= hm_next;
                av_reg    <= av_next;
                abl_reg   <= abl_next;
                pbl_reg   <= pbl_next;
                len_reg   <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== hdl/cis_checker.sv =====
// ----------------------------------------------------------------------------
// cis_checker
// port-level checks for the cbor item skipper
// ----------------------------------------------------------------------------
module cis_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input cis_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input cis_pkg::out_item_t out_item
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // every request yields a result next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("request produced no result");

    // a new item always starts its count at one
    a_begin_len: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_item.begin_item |=> out_item.item_length == 16'd1)
        else $error("item length not restarted");

    // completion leaves no open frame
    a_done_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == cis_pkg::ST_DONE |-> out_item.nesting_depth == 5'd0)
        else $error("item complete with open frames");

endmodule

bind cbor_item_skipper_top cis_checker u_cis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
